/* rtl/prgrt_pkg.sv */
// shared widths, register indexes and reset values of the point range gate and transform
package prgrt_pkg;

    localparam int COORD_W   = 32;
    localparam int TRIG_W    = 16;
    localparam int REG_W     = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_X     = 3'd0,
        REG_ROT_Y     = 3'd1,
        REG_ROT_Z     = 3'd2,
        REG_SHIFT_X   = 3'd3,
        REG_SHIFT_Y   = 3'd4,
        REG_SHIFT_Z   = 3'd5,
        REG_MIN_RANGE = 3'd6,
        REG_MAX_RANGE = 3'd7
    } cfg_idx_t;

    localparam logic [REG_W-1:0] ROT_RESET       = 32'h4000_0000;
    localparam logic [REG_W-1:0] SHIFT_RESET     = 32'h0000_0000;
    localparam logic [REG_W-1:0] MIN_RANGE_RESET = 32'd5898;
    localparam logic [REG_W-1:0] MAX_RANGE_RESET = 32'd1638400;

endpackage

/* rtl/prgrt_if.sv */
// valid/ready channel interfaces for input points and transformed results
interface prgrt_point_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [prgrt_pkg::COORD_W-1:0]      point_x;
    logic signed [prgrt_pkg::COORD_W-1:0]      point_y;
    logic signed [prgrt_pkg::COORD_W-1:0]      point_z;

    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface prgrt_result_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      kept;
    logic signed [prgrt_pkg::COORD_W-1:0]      moved_x;
    logic signed [prgrt_pkg::COORD_W-1:0]      moved_y;
    logic signed [prgrt_pkg::COORD_W-1:0]      moved_z;

    modport source (output valid, output kept, output moved_x, output moved_y, output moved_z,
                    input ready);
    modport sink   (input valid, input kept, input moved_x, input moved_y, input moved_z,
                    output ready);
endinterface

/* rtl/point_range_gate_rigid_transform_top.sv */
// point range gate with z-x-y rotation, translation and saturation, seven-stage pipeline
//
//   channel   dir   handshake          payload
//   points    in    valid / ready      point_x, point_y, point_z
//   results   out   valid / ready      kept, moved_x, moved_y, moved_z
//   cfg       in    cfg_we             cfg_index, cfg_data
//
// one point per cycle sustained while results is ready; a point passes seven register stages
// (squares and z products, range sum and z rounding, gate compare and x products,
// x rounding, y products, y rounding, translation and saturation)
// reset clears the stage valid bits and loads the register defaults
// each stage holds its beat only while the next one is full, so bubbles close up;
// ready drops only when all seven stages hold beats and results is stalled
module point_range_gate_rigid_transform_top #(
    parameter int COORD_FRAC_BITS = 16,
    parameter int TRIG_FRAC_BITS  = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    prgrt_point_if.sink                       points,
    prgrt_result_if.source                    results,
    input  logic                              cfg_we,
    input  logic [prgrt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [prgrt_pkg::REG_W-1:0]       cfg_data
);

    localparam int NST   = 7;
    localparam int CW    = prgrt_pkg::COORD_W;
    localparam int TW    = prgrt_pkg::TRIG_W;
    localparam int RW    = prgrt_pkg::REG_W;
    localparam int SQ_W  = 2 * CW - 1;
    localparam int R2_W  = 2 * CW;
    localparam int LIM_W = RW + COORD_FRAC_BITS;
    // rotation stage widths: products, rounded sums
    localparam int P1W   = TW + CW;
    localparam int S1W   = P1W + 2;
    localparam int X1W   = S1W - TRIG_FRAC_BITS;
    localparam int P2W   = TW + X1W;
    localparam int S2W   = P2W + 2;
    localparam int X2W   = S2W - TRIG_FRAC_BITS;
    localparam int P3W   = TW + X2W;
    localparam int S3W   = P3W + 2;
    localparam int X3W   = S3W - TRIG_FRAC_BITS;
    localparam int FW    = X3W + 1;

    localparam logic signed [S1W-1:0] RND1    = S1W'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [S2W-1:0] RND2    = S2W'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [S3W-1:0] RND3    = S3W'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [FW-1:0]  SAT_MAX = FW'(32'sh7fff_ffff);
    localparam logic signed [FW-1:0]  SAT_MIN = FW'(32'sh8000_0000);

    // configuration registers
    logic [RW-1:0]        rot_x_reg;
    logic [RW-1:0]        rot_y_reg;
    logic [RW-1:0]        rot_z_reg;
    logic signed [CW-1:0] shift_x_reg;
    logic signed [CW-1:0] shift_y_reg;
    logic signed [CW-1:0] shift_z_reg;
    logic [RW-1:0]        min_range_reg;
    logic [RW-1:0]        max_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_x_reg     <= prgrt_pkg::ROT_RESET;
            rot_y_reg     <= prgrt_pkg::ROT_RESET;
            rot_z_reg     <= prgrt_pkg::ROT_RESET;
            shift_x_reg   <= prgrt_pkg::SHIFT_RESET;
            shift_y_reg   <= prgrt_pkg::SHIFT_RESET;
            shift_z_reg   <= prgrt_pkg::SHIFT_RESET;
            min_range_reg <= prgrt_pkg::MIN_RANGE_RESET;
            max_range_reg <= prgrt_pkg::MAX_RANGE_RESET;
        end
        else if (cfg_we)
        begin
            case (prgrt_pkg::cfg_idx_t'(cfg_index))
                prgrt_pkg::REG_ROT_X:     rot_x_reg     <= cfg_data;
                prgrt_pkg::REG_ROT_Y:     rot_y_reg     <= cfg_data;
                prgrt_pkg::REG_ROT_Z:     rot_z_reg     <= cfg_data;
                prgrt_pkg::REG_SHIFT_X:   shift_x_reg   <= cfg_data;
                prgrt_pkg::REG_SHIFT_Y:   shift_y_reg   <= cfg_data;
                prgrt_pkg::REG_SHIFT_Z:   shift_z_reg   <= cfg_data;
                prgrt_pkg::REG_MIN_RANGE: min_range_reg <= cfg_data;
                prgrt_pkg::REG_MAX_RANGE: max_range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [TW-1:0] cx, sx, cy, sy, cz, sz;
    assign cx = rot_x_reg[RW-1:TW];
    assign sx = rot_x_reg[TW-1:0];
    assign cy = rot_y_reg[RW-1:TW];
    assign sy = rot_y_reg[TW-1:0];
    assign cz = rot_z_reg[RW-1:TW];
    assign sz = rot_z_reg[TW-1:0];

    logic [R2_W-1:0] lim_lo, lim_hi;
    assign lim_lo = {{(R2_W-LIM_W){1'b0}}, min_range_reg, {COORD_FRAC_BITS{1'b0}}};
    assign lim_hi = {{(R2_W-LIM_W){1'b0}}, max_range_reg, {COORD_FRAC_BITS{1'b0}}};

    // stage control
    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] adv;
    logic [NST-1:0] ld;

    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || results.ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
        v_next[0] = adv[0] ? points.valid : v_reg[0];
        ld[0]     = adv[0] && points.valid;
        for (int i = 1; i < NST; i++)
        begin
            v_next[i] = adv[i] ? v_reg[i-1] : v_reg[i];
            ld[i]     = adv[i] && v_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign points.ready = adv[0];

    // stage 0: squares and z rotation products
    logic signed [R2_W-1:0] sqx_full, sqy_full, sqz_full;
    logic [SQ_W-1:0]        s0_sqx_reg, s0_sqy_reg, s0_sqz_reg;
    logic signed [P1W-1:0]  s0_pa_next, s0_pb_next, s0_pc_next, s0_pd_next;
    logic signed [P1W-1:0]  s0_pa_reg, s0_pb_reg, s0_pc_reg, s0_pd_reg;
    logic signed [CW-1:0]   s0_z_reg;

    always_comb
    begin
        sqx_full   = points.point_x * points.point_x;
        sqy_full   = points.point_y * points.point_y;
        sqz_full   = points.point_z * points.point_z;
        s0_pa_next = cz * points.point_x;
        s0_pb_next = sz * points.point_y;
        s0_pc_next = sz * points.point_x;
        s0_pd_next = cz * points.point_y;
    end

    // stage 1: range sum and z rotation rounding
    logic [R2_W-1:0]        s1_r2_next, s1_r2_reg;
    logic signed [S1W-1:0]  x1_sum, y1_sum;
    logic signed [X1W-1:0]  s1_x1_next, s1_y1_next;
    logic signed [X1W-1:0]  s1_x1_reg, s1_y1_reg;
    logic signed [CW-1:0]   s1_z1_reg;

    always_comb
    begin
        s1_r2_next = R2_W'(s0_sqx_reg) + R2_W'(s0_sqy_reg) + R2_W'(s0_sqz_reg);
        x1_sum     = S1W'(s0_pa_reg) - S1W'(s0_pb_reg) + RND1;
        y1_sum     = S1W'(s0_pc_reg) + S1W'(s0_pd_reg) + RND1;
        s1_x1_next = x1_sum[S1W-1:TRIG_FRAC_BITS];
        s1_y1_next = y1_sum[S1W-1:TRIG_FRAC_BITS];
    end

    // stage 2: range gate and x rotation products
    logic                   s2_kept_next, s2_kept_reg;
    logic signed [X1W-1:0]  s2_x1_reg;
    logic signed [P2W-1:0]  s2_qa_next, s2_qb_next, s2_qc_next, s2_qd_next;
    logic signed [P2W-1:0]  s2_qa_reg, s2_qb_reg, s2_qc_reg, s2_qd_reg;

    always_comb
    begin
        s2_kept_next = (s1_r2_reg > lim_lo) && (s1_r2_reg < lim_hi);
        s2_qa_next   = cx * s1_y1_reg;
        s2_qb_next   = sx * s1_z1_reg;
        s2_qc_next   = cx * s1_z1_reg;
        s2_qd_next   = sx * s1_y1_reg;
    end

    // stage 3: x rotation rounding
    logic                   s3_kept_reg;
    logic signed [X1W-1:0]  s3_x1_reg;
    logic signed [S2W-1:0]  y2_sum, z2_sum;
    logic signed [X2W-1:0]  s3_y2_next, s3_z2_next;
    logic signed [X2W-1:0]  s3_y2_reg, s3_z2_reg;

    always_comb
    begin
        y2_sum     = S2W'(s2_qa_reg) + S2W'(s2_qb_reg) + RND2;
        z2_sum     = S2W'(s2_qc_reg) - S2W'(s2_qd_reg) + RND2;
        s3_y2_next = y2_sum[S2W-1:TRIG_FRAC_BITS];
        s3_z2_next = z2_sum[S2W-1:TRIG_FRAC_BITS];
    end

    // stage 4: y rotation products
    logic                   s4_kept_reg;
    logic signed [X2W-1:0]  s4_y2_reg;
    logic signed [P3W-1:0]  s4_ra_next, s4_rb_next, s4_rc_next, s4_rd_next;
    logic signed [P3W-1:0]  s4_ra_reg, s4_rb_reg, s4_rc_reg, s4_rd_reg;

    always_comb
    begin
        s4_ra_next = cy * s3_x1_reg;
        s4_rb_next = sy * s3_z2_reg;
        s4_rc_next = sy * s3_x1_reg;
        s4_rd_next = cy * s3_z2_reg;
    end

    // stage 5: y rotation rounding
    logic                   s5_kept_reg;
    logic signed [X2W-1:0]  s5_y2_reg;
    logic signed [S3W-1:0]  x3_sum, z3_sum;
    logic signed [X3W-1:0]  s5_x3_next, s5_z3_next;
    logic signed [X3W-1:0]  s5_x3_reg, s5_z3_reg;

    always_comb
    begin
        x3_sum     = S3W'(s4_ra_reg) - S3W'(s4_rb_reg) + RND3;
        z3_sum     = S3W'(s4_rc_reg) + S3W'(s4_rd_reg) + RND3;
        s5_x3_next = x3_sum[S3W-1:TRIG_FRAC_BITS];
        s5_z3_next = z3_sum[S3W-1:TRIG_FRAC_BITS];
    end

    // stage 6: translate, saturate, zero a dropped point
    logic signed [FW-1:0]  fx, fy, fz;
    logic signed [CW-1:0]  s6_x_next, s6_y_next, s6_z_next;
    logic signed [CW-1:0]  s6_x_reg, s6_y_reg, s6_z_reg;
    logic                  s6_kept_reg;

    function automatic logic signed [CW-1:0] sat_coord(input logic signed [FW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[CW-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[CW-1:0];
        end
        else
        begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        fx = FW'(s5_x3_reg) + FW'(shift_x_reg);
        fy = FW'(s5_y2_reg) + FW'(shift_y_reg);
        fz = FW'(s5_z3_reg) + FW'(shift_z_reg);
        s6_x_next = s5_kept_reg ? sat_coord(fx) : '0;
        s6_y_next = s5_kept_reg ? sat_coord(fy) : '0;
        s6_z_next = s5_kept_reg ? sat_coord(fz) : '0;
    end

    // payload registers, loaded as a beat moves in
    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s0_sqx_reg <= sqx_full[SQ_W-1:0];
            s0_sqy_reg <= sqy_full[SQ_W-1:0];
            s0_sqz_reg <= sqz_full[SQ_W-1:0];
            s0_pa_reg  <= s0_pa_next;
            s0_pb_reg  <= s0_pb_next;
            s0_pc_reg  <= s0_pc_next;
            s0_pd_reg  <= s0_pd_next;
            s0_z_reg   <= points.point_z;
        end
        if (ld[1])
        begin
            s1_r2_reg <= s1_r2_next;
            s1_x1_reg <= s1_x1_next;
            s1_y1_reg <= s1_y1_next;
            s1_z1_reg <= s0_z_reg;
        end
        if (ld[2])
        begin
            s2_kept_reg <= s2_kept_next;
            s2_x1_reg   <= s1_x1_reg;
            s2_qa_reg   <= s2_qa_next;
            s2_qb_reg   <= s2_qb_next;
            s2_qc_reg   <= s2_qc_next;
            s2_qd_reg   <= s2_qd_next;
        end
        if (ld[3])
        begin
            s3_kept_reg <= s2_kept_reg;
            s3_x1_reg   <= s2_x1_reg;
            s3_y2_reg   <= s3_y2_next;
            s3_z2_reg   <= s3_z2_next;
        end
        if (ld[4])
        begin
            s4_kept_reg <= s3_kept_reg;
            s4_y2_reg   <= s3_y2_reg;
            s4_ra_reg   <= s4_ra_next;
            s4_rb_reg   <= s4_rb_next;
            s4_rc_reg   <= s4_rc_next;
            s4_rd_reg   <= s4_rd_next;
        end
        if (ld[5])
        begin
            s5_kept_reg <= s4_kept_reg;
            s5_y2_reg   <= s4_y2_reg;
            s5_x3_reg   <= s5_x3_next;
            s5_z3_reg   <= s5_z3_next;
        end
        if (ld[6])
        begin
            s6_kept_reg <= s5_kept_reg;
            s6_x_reg    <= s6_x_next;
            s6_y_reg    <= s6_y_next;
            s6_z_reg    <= s6_z_next;
        end
    end

    assign results.valid   = v_reg[NST-1];
    assign results.kept    = s6_kept_reg;
    assign results.moved_x = s6_x_reg;
    assign results.moved_y = s6_y_reg;
    assign results.moved_z = s6_z_reg;

    // a dropped point leaves with zero coordinates
    a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.kept |->
            results.moved_x == '0 && results.moved_y == '0 && results.moved_z == '0)
        else $error("dropped point with nonzero coordinates");

    // input back-pressure only when every stage is occupied
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !points.ready |-> &v_reg)
        else $error("points stalled while a stage is empty");

    // beats in flight grow by one on an input beat alone
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && points.ready && !(results.valid && results.ready) |=>
            $countones(v_reg) == $past($countones(v_reg)) + 1)
        else $error("input beat lost or duplicated in pipeline");

    // and shrink by one on an output beat alone
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        !(points.valid && points.ready) && results.valid && results.ready |=>
            $countones(v_reg) == $past($countones(v_reg)) - 1)
        else $error("output beat lost or duplicated in pipeline");

endmodule
